// ===== rtl/core/dht_pkg.sv =====
package dht_pkg;

    localparam int KIND_W     = 2;
    localparam int KEY_W      = 31;
    localparam int STATUS_W   = 2;
    localparam int MARK_W     = 2;
    localparam int DIGIT_W    = 8;
    localparam int KEY_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int Q_DEPTH    = 2;

    localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_GONE  = 2'd2;

    typedef struct packed {
        logic clearing;
        logic idle;
    } t_back_stat;

endpackage

// ===== rtl/core/dht_queue.sv =====
module dht_queue #(
    parameter int WIDTH = 55,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_fill;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dht_front.sv =====
module dht_front #(
    parameter int SLOT_COUNT = 1021,
    parameter int STEP_PRIME = 11
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dht_pkg::KIND_W-1:0]     i_kind,
    input  logic [dht_pkg::KEY_W-1:0]      i_key,
    input  dht_pkg::t_back_stat            i_stat,
    output logic                           o_push,
    output logic [dht_pkg::KIND_W+dht_pkg::KEY_W+2*$clog2(SLOT_COUNT)-1:0] o_job,
    input  logic                           i_q_full
);

    import dht_pkg::*;

    localparam int HW       = $clog2(SLOT_COUNT);
    localparam int SW       = $clog2(STEP_PRIME);
    localparam int SPW      = $clog2(STEP_PRIME + 1);
    localparam int RW       = ((HW > SW) ? HW : SW) + DIGIT_W;
    localparam int KPAD     = KEY_DIGITS * DIGIT_W;
    localparam int S_DIGITS = (SPW + DIGIT_W - 1) / DIGIT_W;
    localparam int SPAD     = S_DIGITS * DIGIT_W;
    localparam bit NEED_SRED = (STEP_PRIME >= SLOT_COUNT);
    localparam int N_DIG    = KEY_DIGITS + (NEED_SRED ? S_DIGITS : 0);
    localparam int DCW      = $clog2(N_DIG + 1);

    localparam logic [RW-1:0] MOD_T = RW'(SLOT_COUNT);
    localparam logic [RW-1:0] MOD_S = RW'(STEP_PRIME);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RED  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]        r_fstate;
    logic [DCW-1:0]    r_cnt;
    logic [KIND_W-1:0] r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [KPAD-1:0]   r_kshift;
    logic [SPAD-1:0]   r_sshift;
    logic [HW-1:0]     r_home;
    logic [SW-1:0]     r_smod;
    logic [HW-1:0]     r_sred;

    logic               in_ready;
    logic               accept;
    logic [DIGIT_W-1:0] dig_k;
    logic [DIGIT_W-1:0] dig_s;
    logic [HW-1:0]      home_nx;
    logic [SW-1:0]      smod_nx;
    logic [HW-1:0]      sred_nx;
    logic [SPW-1:0]     s_val;
    logic [SPW-1:0]     s_val_nx;
    logic [HW-1:0]      step_out;

    // One digit of the running remainder: shift in eight bits, then take out
    // the modulus times 128, 64, ... 1 wherever it fits.
    function automatic logic [RW-1:0] red_digit(input logic [RW-1:0] r,
                                                input logic [DIGIT_W-1:0] d,
                                                input logic [RW-1:0] m);
        logic [RW-1:0] t;
        logic [RW-1:0] ms;
        t = {r[RW-DIGIT_W-1:0], d};
        for (int j = DIGIT_W - 1; j >= 0; j--) begin
            ms = m << j;
            if (t >= ms) begin
                t = t - ms;
            end
        end
        return t;
    endfunction

    assign in_ready   = !i_stat.clearing &&
                        ((r_fstate == F_IDLE) || ((r_fstate == F_PUSH) && !i_q_full));
    assign o_in_stall = !in_ready;
    assign accept     = i_in_valid && in_ready;
    assign o_push     = (r_fstate == F_PUSH) && !i_q_full;

    always_comb begin
        dig_k    = r_kshift[KPAD-1 -: DIGIT_W];
        dig_s    = r_sshift[SPAD-1 -: DIGIT_W];
        home_nx  = HW'(red_digit(RW'(r_home), dig_k, MOD_T));
        smod_nx  = SW'(red_digit(RW'(r_smod), dig_k, MOD_S));
        sred_nx  = HW'(red_digit(RW'(r_sred), dig_s, MOD_T));
        s_val    = SPW'(STEP_PRIME) - SPW'(r_smod);
        s_val_nx = SPW'(STEP_PRIME) - SPW'(smod_nx);
        step_out = NEED_SRED ? r_sred : HW'(s_val);
        o_job    = {r_kind, r_key, r_home, step_out};
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_key    <= i_key;
            r_kshift <= KPAD'(i_key);
            r_home   <= '0;
            r_smod   <= '0;
            r_sred   <= '0;
        end else if (r_fstate == F_RED) begin
            if (r_cnt < DCW'(KEY_DIGITS)) begin
                r_home   <= home_nx;
                r_smod   <= smod_nx;
                r_kshift <= r_kshift << DIGIT_W;
                if (r_cnt == DCW'(KEY_DIGITS - 1)) begin
                    r_sshift <= SPAD'(s_val_nx);
                end
            end else begin
                r_sred   <= sred_nx;
                r_sshift <= r_sshift << DIGIT_W;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= F_IDLE;
            r_cnt    <= '0;
        end else if (accept) begin
            r_fstate <= F_RED;
            r_cnt    <= '0;
        end else begin
            case (r_fstate)
                F_RED: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DCW'(N_DIG - 1)) begin
                        r_fstate <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_fstate <= F_IDLE;
                    end
                end
                F_IDLE: begin
                    r_fstate <= F_IDLE;
                end
                default: begin
                    r_fstate <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/dht_back.sv =====
module dht_back #(
    parameter int SLOT_COUNT = 1021
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [dht_pkg::KIND_W+dht_pkg::KEY_W+2*$clog2(SLOT_COUNT)-1:0] i_job,
    input  logic                         i_q_empty,
    output logic                         o_pop,
    output dht_pkg::t_back_stat          o_stat,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dht_pkg::STATUS_W-1:0] o_status,
    output logic [$clog2(SLOT_COUNT)-1:0] o_slot,
    output logic [$clog2(SLOT_COUNT+1)-1:0] o_key_total
);

    import dht_pkg::*;

    localparam int HW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int JOB_W = KIND_W + KEY_W + 2 * HW;

    localparam logic [HW-1:0] LAST_SLOT = HW'(SLOT_COUNT - 1);
    localparam logic [HW:0]   SIZE_EXT  = (HW + 1)'(SLOT_COUNT);
    localparam logic [CW-1:0] FULL_CNT  = CW'(SLOT_COUNT);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_PROBE = 2'd2;
    localparam logic [1:0] B_DONE  = 2'd3;

    logic [MARK_W-1:0] mark_mem [SLOT_COUNT];
    logic [KEY_W-1:0]  key_mem  [SLOT_COUNT];

    logic [1:0]          r_state, n_state;
    logic [HW-1:0]       r_clr_addr, n_clr_addr;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [HW-1:0]       r_home, n_home;
    logic [HW-1:0]       r_step, n_step;
    logic [HW-1:0]       r_p, n_p;
    logic [HW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_count, n_count;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [HW-1:0]       r_res_slot, n_res_slot;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic [HW-1:0]       r_o_slot, n_o_slot;
    logic [CW-1:0]       r_o_total, n_o_total;
    logic [MARK_W-1:0]   r_mark_rd;
    logic [KEY_W-1:0]    r_key_rd;

    logic [KIND_W-1:0] q_kind;
    logic [KEY_W-1:0]  q_key;
    logic [HW-1:0]     q_home;
    logic [HW-1:0]     q_step;
    logic [HW-1:0]     rd_addr;
    logic [HW-1:0]     wr_addr;
    logic [MARK_W-1:0] wr_mark;
    logic              mark_we;
    logic              key_we;
    logic [HW:0]       p_sum;
    logic [HW-1:0]     p_next;
    logic              last_probe;

    assign q_kind = i_job[JOB_W-1 -: KIND_W];
    assign q_key  = i_job[2*HW +: KEY_W];
    assign q_home = i_job[HW +: HW];
    assign q_step = i_job[HW-1:0];

    assign o_stat.clearing = (r_state == B_CLEAR);
    assign o_stat.idle     = (r_state == B_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_slot          = r_o_slot;
    assign o_key_total     = r_o_total;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_kind       = r_kind;
        n_key        = r_key;
        n_home       = r_home;
        n_step       = r_step;
        n_p          = r_p;
        n_n          = r_n;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && i_out_stall;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_total    = r_o_total;
        o_pop        = 1'b0;
        rd_addr      = r_p;
        wr_addr      = r_p;
        wr_mark      = MARK_USED;
        mark_we      = 1'b0;
        key_we       = 1'b0;

        p_sum      = {1'b0, r_p} + {1'b0, r_step};
        p_next     = (p_sum >= SIZE_EXT) ? HW'(p_sum - SIZE_EXT) : HW'(p_sum);
        last_probe = (r_n == LAST_SLOT);

        case (r_state)
            B_CLEAR: begin
                mark_we = 1'b1;
                wr_addr = r_clr_addr;
                wr_mark = MARK_EMPTY;
                if (r_clr_addr == LAST_SLOT) begin
                    n_state = B_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop      = 1'b1;
                    n_kind     = q_kind;
                    n_key      = q_key;
                    n_home     = q_home;
                    n_step     = q_step;
                    n_p        = q_home;
                    n_n        = '0;
                    rd_addr    = q_home;
                    n_res_slot = '0;
                    if ((q_kind == OP_INSERT) && (r_count == FULL_CNT)) begin
                        n_res_status = ST_FULL;
                        n_state      = B_DONE;
                    end else if ((q_kind == OP_INSERT) || (q_kind == OP_SEARCH) ||
                                 (q_kind == OP_DELETE)) begin
                        n_state = B_PROBE;
                    end else begin
                        n_res_status = ST_MISS;
                        n_state      = B_DONE;
                    end
                end
            end
            B_PROBE: begin
                if (r_kind == OP_INSERT) begin
                    if (r_mark_rd != MARK_USED) begin
                        mark_we      = 1'b1;
                        key_we       = 1'b1;
                        wr_mark      = MARK_USED;
                        n_count      = r_count + 1'b1;
                        n_res_status = ST_DONE;
                        n_res_slot   = r_p;
                        n_state      = B_DONE;
                    end else if (last_probe) begin
                        n_res_status = ST_FULL;
                        n_state      = B_DONE;
                    end else begin
                        rd_addr = p_next;
                        n_p     = p_next;
                        n_n     = r_n + 1'b1;
                    end
                end else begin
                    if (r_mark_rd == MARK_EMPTY) begin
                        n_res_status = ST_MISS;
                        n_state      = B_DONE;
                    end else if ((r_mark_rd == MARK_USED) && (r_key_rd == r_key)) begin
                        if (r_kind == OP_DELETE) begin
                            mark_we = 1'b1;
                            wr_mark = MARK_GONE;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        n_res_status = ST_DONE;
                        n_res_slot   = r_p;
                        n_state      = B_DONE;
                    end else if (((r_n != '0) && (r_p == r_home)) || last_probe) begin
                        // Back at the home slot, or every slot has been probed.
                        n_res_status = ST_MISS;
                        n_state      = B_DONE;
                    end else begin
                        rd_addr = p_next;
                        n_p     = p_next;
                        n_n     = r_n + 1'b1;
                    end
                end
            end
            B_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_res_status;
                    n_o_slot    = r_res_slot;
                    n_o_total   = r_count;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[wr_addr] <= wr_mark;
        end
        r_mark_rd <= mark_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_addr] <= r_key;
        end
        r_key_rd <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_home       <= n_home;
        r_step       <= n_step;
        r_p          <= n_p;
        r_n          <= n_n;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_total    <= n_o_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/double_hash_table_top.sv =====
// Open-addressing hash set with double hashing over SLOT_COUNT slots. Each
// item (insert, search or delete of a 31-bit key) yields one result: status,
// slot and the key count afterwards. After reset the block clears the slot
// marks and accepts no item until that pass ends. The front reduces the key
// modulo SLOT_COUNT and STEP_PRIME one byte per cycle (and then the step
// modulo SLOT_COUNT when STEP_PRIME is not below SLOT_COUNT), and it takes
// no new item until the job of the last one goes into the queue. The back
// fetches the home slot, probes the slot memory (one read port, one write
// port) one slot at a time, and then loads the result register; a refused
// insert or an unused operation code goes from the fetch straight to the
// result register.
module double_hash_table_top #(
    parameter int SLOT_COUNT = 1021,
    parameter int STEP_PRIME = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [dht_pkg::KIND_W-1:0]   i_kind,
    input  logic [dht_pkg::KEY_W-1:0]    i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dht_pkg::STATUS_W-1:0] o_status,
    output logic [$clog2(SLOT_COUNT)-1:0] o_slot,
    output logic [$clog2(SLOT_COUNT+1)-1:0] o_key_total
);

    import dht_pkg::*;

    localparam int HW    = $clog2(SLOT_COUNT);
    localparam int CW    = $clog2(SLOT_COUNT + 1);
    localparam int JOB_W = KIND_W + KEY_W + 2 * HW;

    t_back_stat       stat;
    logic             job_push;
    logic [JOB_W-1:0] job_in;
    logic [JOB_W-1:0] job_out;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    dht_front #(
        .SLOT_COUNT(SLOT_COUNT),
        .STEP_PRIME(STEP_PRIME)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind    (i_kind),
        .i_key     (i_key),
        .i_stat    (stat),
        .o_push    (job_push),
        .o_job     (job_in),
        .i_q_full  (q_full)
    );

    dht_queue #(
        .WIDTH(JOB_W),
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_data (job_out),
        .o_empty(q_empty)
    );

    dht_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job_out),
        .i_q_empty  (q_empty),
        .o_pop      (q_pop),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_slot     (o_slot),
        .o_key_total(o_key_total)
    );

    // No item enters while the slot marks are being cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> o_in_stall)
        else $error("item accepted during the clearing pass");

    // No result can appear before the clearing pass has finished.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.clearing |-> !o_out_valid)
        else $error("result shown during the clearing pass");

    // A result is loaded only from the finishing state, never from idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(stat.idle))
        else $error("result appeared without a finished operation");

    // Failed operations report slot zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |-> (o_slot == '0))
        else $error("nonzero slot on a failed operation");

    // The key count never goes beyond the table size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_total <= CW'(SLOT_COUNT)))
        else $error("key count exceeds table size");

endmodule
